// ===== hdl/sppc_pkg.sv =====
package sppc_pkg;

    // Fixed field widths of the item, result and register beats.
    localparam int unsigned TARGET_W    = 16;
    localparam int unsigned QUOT_W      = 16;
    localparam int unsigned COILS_W     = 4;
    localparam int unsigned POSITION_W  = 12;
    localparam int unsigned DEADBAND_W  = 12;
    localparam int unsigned DELAY_W     = 16;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    // Reset values of the configuration registers.
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST   = 12'd4;
    localparam logic [DELAY_W-1:0]    STEP_DELAY_RST = 16'd1000;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY = 1'd1;

    // Item kinds.
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_TARGET = 2'd1,
        OP_SLEEP  = 2'd2,
        OP_WAKE   = 2'd3
    } t_op;

    // One item held in the input register, with its precomputed quotient.
    typedef struct packed {
        t_op                 op;
        logic [TARGET_W-1:0] target;
        logic [QUOT_W-1:0]   quot;
    } t_item;

    // Half-step coil drive table, indexed by position modulo 8.
    function automatic logic [COILS_W-1:0] coil_pattern(input logic [2:0] idx);
        logic [COILS_W-1:0] pat;
        case (idx)
            3'd0: pat = 4'd1;
            3'd1: pat = 4'd3;
            3'd2: pat = 4'd2;
            3'd3: pat = 4'd6;
            3'd4: pat = 4'd4;
            3'd5: pat = 4'd12;
            3'd6: pat = 4'd8;
            3'd7: pat = 4'd9;
            default: pat = 4'd0;
        endcase
        return pat;
    endfunction

endpackage

// ===== hdl/sppc_in_if.sv =====
interface sppc_in_if
    import sppc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [TARGET_W-1:0] target_position;

    modport source (output valid, output op, output target_position, input ready);
    modport sink   (input valid, input op, input target_position, output ready);
endinterface

// ===== hdl/sppc_out_if.sv =====
interface sppc_out_if
    import sppc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [COILS_W-1:0]    coils;
    logic                  moving;
    logic [POSITION_W-1:0] position;

    modport source (output valid, output coils, output moving, output position, input ready);
    modport sink   (input valid, input coils, input moving, input position, output ready);
endinterface

// ===== hdl/sppc_cfg_if.sv =====
interface sppc_cfg_if
    import sppc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/sppc_front.sv =====
module sppc_front
    import sppc_pkg::*;
#(
    parameter int unsigned STEPS_PER_REV = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sppc_in_if.sink    i_in,
    input  logic       i_take,
    output logic       o_valid,
    output t_item      o_item
);

    // Reciprocal of the step count, rounded up; exact quotients for 16-bit targets.
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / STEPS_PER_REV + 64'd1);

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic [48:0] quot_prod;

    // The register takes a beat when empty or when the core drains it this cycle.
    assign i_in.ready = !r_valid || i_take;

    // Quotient of the target by the step count, taken as the beat arrives.
    assign quot_prod = 49'(i_in.target_position) * 49'(RECIP);

    always_comb begin
        n_item.op     = t_op'(i_in.op);
        n_item.target = i_in.target_position;
        n_item.quot   = quot_prod[32 +: QUOT_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hdl/sppc_core.sv =====
module sppc_core
    import sppc_pkg::*;
#(
    parameter int unsigned STEPS_PER_REV = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_take,
    sppc_cfg_if.sink   i_cfg,
    sppc_out_if.source o_out
);

    localparam int unsigned PW = $clog2(STEPS_PER_REV);
    localparam logic [16:0]  N17  = 17'(STEPS_PER_REV);
    localparam logic [PW:0]  N_P1 = (PW+1)'(STEPS_PER_REV);
    localparam logic [PW+1:0] N_P2 = (PW+2)'(STEPS_PER_REV);
    localparam logic [PW-1:0] LAST_POS = PW'(STEPS_PER_REV - 1);

    // Motion state and configuration.
    logic [PW-1:0]          r_pos, n_pos;
    logic [PW-1:0]          r_tgt, n_tgt;
    logic                   r_asleep, n_asleep;
    logic                   r_energized, n_energized;
    logic [DELAY_W-1:0]     r_ticks, n_ticks;
    logic [DEADBAND_W-1:0]  r_deadband;
    logic [DELAY_W-1:0]     r_step_delay;

    // Result register.
    logic                  r_out_valid;
    logic [COILS_W-1:0]    r_coils, n_coils;
    logic                  r_moving, n_moving;
    logic [POSITION_W-1:0] r_position;

    logic [32:0]            quot_mul;
    logic [16:0]            tgt_rem;
    logic [PW:0]            diff_raw;
    logic [PW-1:0]          wrap_err;
    logic                   cw;
    logic [PW:0]            mag;
    logic [DEADBAND_W-1:0]  dz_eff;
    logic                   outside;
    logic [DELAY_W-1:0]     tick_cnt;
    logic [PW-1:0]          pos_up;
    logic [PW-1:0]          pos_down;
    logic [16:0]            pos_wide;

    // The item moves on whenever the result register is free or being drained.
    assign o_take = i_valid && (!r_out_valid || o_out.ready);

    // Target modulo the step count from the precomputed quotient.
    assign quot_mul = 33'(i_item.quot) * 33'(N17);
    assign tgt_rem  = 17'(i_item.target) - quot_mul[16:0];

    // Wrapped error and shortest direction; half a turn goes clockwise.
    assign diff_raw = {1'b0, r_tgt} + N_P1 - {1'b0, r_pos};
    assign wrap_err = (diff_raw >= N_P1) ? PW'(diff_raw - N_P1) : diff_raw[PW-1:0];
    assign cw       = ({1'b0, wrap_err, 1'b0} <= N_P2);
    assign mag      = cw ? {1'b0, wrap_err} : (N_P1 - {1'b0, wrap_err});
    assign dz_eff   = (r_deadband == '0) ? DEADBAND_W'(1) : r_deadband;
    assign outside  = (17'(mag) >= 17'(dz_eff));

    // Saturating tick count and neighboring positions.
    assign tick_cnt = (r_ticks == '1) ? r_ticks : r_ticks + DELAY_W'(1);
    assign pos_up   = (r_pos == LAST_POS) ? '0 : r_pos + PW'(1);
    assign pos_down = (r_pos == '0) ? LAST_POS : r_pos - PW'(1);

    // Next state for the item at the head of the input register.
    always_comb begin
        n_pos       = r_pos;
        n_tgt       = r_tgt;
        n_asleep    = r_asleep;
        n_energized = r_energized;
        n_ticks     = r_ticks;
        n_moving    = 1'b0;
        case (i_item.op)
            OP_TICK: begin
                n_ticks = tick_cnt;
                if (!r_asleep && outside) begin
                    n_moving = 1'b1;
                    if (tick_cnt >= r_step_delay) begin
                        n_ticks     = '0;
                        n_pos       = cw ? pos_up : pos_down;
                        n_energized = 1'b1;
                    end
                end
            end
            OP_TARGET: begin
                n_tgt = tgt_rem[PW-1:0];
            end
            OP_SLEEP: begin
                n_energized = 1'b0;
                n_asleep    = 1'b1;
            end
            OP_WAKE: begin
                n_energized = 1'b1;
                n_asleep    = 1'b0;
            end
            default: begin
                n_moving = 1'b0;
            end
        endcase
        n_coils = n_energized ? coil_pattern(n_pos[2:0]) : '0;
    end

    assign pos_wide = 17'(n_pos);

    // State update, one item per cycle while the result register is free or drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_tgt       <= '0;
            r_asleep    <= 1'b0;
            r_energized <= 1'b0;
            r_ticks     <= '1;
        end else if (o_take) begin
            r_pos       <= n_pos;
            r_tgt       <= n_tgt;
            r_asleep    <= n_asleep;
            r_energized <= n_energized;
            r_ticks     <= n_ticks;
        end
    end

    // Configuration registers; writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband   <= DEADBAND_RST;
            r_step_delay <= STEP_DELAY_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DEADBAND:   r_deadband   <= i_cfg.data[DEADBAND_W-1:0];
                CFG_STEP_DELAY: r_step_delay <= i_cfg.data;
                default:        r_step_delay <= r_step_delay;
            endcase
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_coils    <= n_coils;
            r_moving   <= n_moving;
            r_position <= pos_wide[POSITION_W-1:0];
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.coils    = r_coils;
    assign o_out.moving   = r_moving;
    assign o_out.position = r_position;

endmodule

// ===== hdl/stepper_pointer_position_controller_top.sv =====
// Four-coil stepper pointer controller with half-step drive.
// Input channel: each beat carries an op (tick, set target, sleep, wake) and a
// target position in half-steps, reduced modulo STEPS_PER_REV on set target.
// Output channel: exactly one result beat per input beat, in order, with the
// coil pattern, the moving flag and the position after the item.
// Configuration channel: index 0 writes the dead zone, index 1 the step delay;
// it is always ready and should be written only while no item is in flight.
// An accepted item is held in the input register and its result is then registered
// in the result register, where it is offered. Throughput is one item per cycle
// while the receiver takes results, set by the state update after the input
// register; the reciprocal multiply for the target reduction sits before it.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; input ready drops only when both are full.
// Reset (synchronous, active low) empties both registers, puts the pointer and
// target at zero, awake with coils off, the tick count saturated, and the dead
// zone and step delay at 4 and 1000.
module stepper_pointer_position_controller_top
    import sppc_pkg::*;
#(
    parameter int unsigned STEPS_PER_REV = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sppc_in_if.sink    i_in,
    sppc_cfg_if.sink   i_cfg,
    sppc_out_if.source o_out
);

    logic  item_valid;
    logic  item_take;
    t_item item;

    // Input register with the target quotient.
    sppc_front #(
        .STEPS_PER_REV(STEPS_PER_REV)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (item_take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    // State update and result register.
    sppc_core #(
        .STEPS_PER_REV(STEPS_PER_REV)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (item_valid),
        .i_item  (item),
        .o_take  (item_take),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

// ===== tb/sv/stepper_pointer_position_controller_top_test.sv =====
`timescale 1ns / 1ps

module stepper_pointer_position_controller_top_test;
    import sppc_pkg::*;

    // One result beat of the controller.
    typedef struct packed {
        logic [COILS_W-1:0]    coils;
        logic                  moving;
        logic [POSITION_W-1:0] position;
    } t_drive;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    // One row of the directed script: an item or a register write.
    typedef struct packed {
        t_row_kind            kind;
        t_op                  op;
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          value;
        logic                 typed;
        t_drive               result;
    } t_script_row;

    // Register setting and length of one random phase.
    typedef struct packed {
        logic [DEADBAND_W-1:0] deadband;
        logic [DELAY_W-1:0]    delay;
        logic [11:0]           items;
        logic                  gapless;
    } t_phase;

    localparam int DIRECTED_ROWS = 33;
    localparam int PHASES        = 10;
    localparam int LONG_STALL    = 60;

    // Half-step coil patterns, nibble k for position modulo 8 equal to k.
    localparam logic [31:0] HALF_STEP_COILS = 32'h98C4_6231;

    localparam t_script_row DIRECTED_SCRIPT [0:DIRECTED_ROWS-1] = '{
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b1, '{4'd0, 1'b0, 12'd0}},
        '{ROW_ITEM, OP_WAKE,   CFG_DEADBAND,   16'h1234, 1'b1, '{4'd1, 1'b0, 12'd0}},
        '{ROW_ITEM, OP_SLEEP,  CFG_DEADBAND,   16'h0000, 1'b1, '{4'd0, 1'b0, 12'd0}},
        '{ROW_ITEM, OP_SLEEP,  CFG_DEADBAND,   16'hFFFF, 1'b1, '{4'd0, 1'b0, 12'd0}},
        '{ROW_ITEM, OP_WAKE,   CFG_DEADBAND,   16'h0000, 1'b1, '{4'd1, 1'b0, 12'd0}},
        '{ROW_ITEM, OP_WAKE,   CFG_DEADBAND,   16'hFFFF, 1'b1, '{4'd1, 1'b0, 12'd0}},
        '{ROW_ITEM, OP_TARGET, CFG_DEADBAND,   16'hFFFF, 1'b1, '{4'd1, 1'b0, 12'd0}},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b1, '{4'd1, 1'b0, 12'd0}},
        '{ROW_ITEM, OP_TARGET, CFG_DEADBAND,   16'h0800, 1'b1, '{4'd1, 1'b0, 12'd0}},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b1, '{4'd3, 1'b1, 12'd1}},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b1, '{4'd3, 1'b1, 12'd1}},
        '{ROW_ITEM, OP_TARGET, CFG_DEADBAND,   16'h1000, 1'b1, '{4'd3, 1'b0, 12'd1}},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b1, '{4'd3, 1'b0, 12'd1}},
        '{ROW_CFG,  OP_TICK,   CFG_STEP_DELAY, 16'h0000, 1'b0, '0},
        '{ROW_CFG,  OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b0, '0},
        '{ROW_ITEM, OP_TARGET, CFG_DEADBAND,   16'hF002, 1'b0, '0},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b0, '0},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b0, '0},
        '{ROW_ITEM, OP_TARGET, CFG_DEADBAND,   16'h8FFF, 1'b0, '0},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b0, '0},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b0, '0},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b0, '0},
        '{ROW_ITEM, OP_SLEEP,  CFG_DEADBAND,   16'h0000, 1'b0, '0},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b0, '0},
        '{ROW_ITEM, OP_WAKE,   CFG_DEADBAND,   16'h0000, 1'b0, '0},
        '{ROW_CFG,  OP_TICK,   CFG_DEADBAND,   16'h0800, 1'b0, '0},
        '{ROW_ITEM, OP_TARGET, CFG_DEADBAND,   16'h07FF, 1'b0, '0},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b0, '0},
        '{ROW_CFG,  OP_TICK,   CFG_DEADBAND,   16'h0FFF, 1'b0, '0},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b0, '0},
        '{ROW_CFG,  OP_TICK,   CFG_STEP_DELAY, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG,  OP_TICK,   CFG_DEADBAND,   16'h0001, 1'b0, '0},
        '{ROW_ITEM, OP_TICK,   CFG_DEADBAND,   16'h0000, 1'b0, '0}
    };

    localparam t_phase PHASE_PLAN [0:PHASES-1] = '{
        '{12'd1,    16'd0,     12'd250, 1'b0},
        '{12'd4,    16'd1,     12'd200, 1'b0},
        '{12'd2,    16'd3,     12'd200, 1'b1},
        '{12'd2048, 16'd0,     12'd100, 1'b0},
        '{12'd0,    16'd2,     12'd150, 1'b0},
        '{12'd16,   16'd0,     12'd150, 1'b0},
        '{12'd3,    16'd65535, 12'd80,  1'b0},
        '{12'd4,    16'd1000,  12'd60,  1'b0},
        '{12'd4095, 16'd5,     12'd60,  1'b0},
        '{12'd1,    16'd0,     12'd100, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    sppc_in_if  item_ch ();
    sppc_cfg_if cfg_ch ();
    sppc_out_if drive_ch ();

    stepper_pointer_position_controller_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_ch),
        .i_cfg   (cfg_ch),
        .o_out   (drive_ch)
    );

    always #2 i_clk = ~i_clk;

    // Pointer state as the block should hold it.
    logic [POSITION_W-1:0] ptr_pos        = '0;
    logic [POSITION_W-1:0] ptr_target     = '0;
    logic                  ptr_asleep     = 1'b0;
    logic                  ptr_energized  = 1'b0;
    logic [15:0]           ptr_ticks      = 16'hFFFF;
    logic [DEADBAND_W-1:0] ptr_deadband   = DEADBAND_RST;
    logic [DELAY_W-1:0]    ptr_step_delay = STEP_DELAY_RST;

    t_drive      drive_queue [$];
    int unsigned mismatch_count = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;
    int unsigned stall_left     = 0;
    int unsigned flow_left      = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Apply one item to the pointer state and return the drive it yields.
    function automatic t_drive advance_pointer(input t_op op, input logic [15:0] tgt);
        logic [POSITION_W-1:0] err;
        logic [POSITION_W-1:0] mag;
        logic [DEADBAND_W-1:0] zone;
        logic                  up;
        t_drive                res;

        res.moving = 1'b0;
        case (op)
            OP_TICK: begin
                if (ptr_ticks != 16'hFFFF)
                    ptr_ticks = ptr_ticks + 16'd1;
                if (!ptr_asleep) begin
                    // Half a turn exactly counts as the clockwise way.
                    err  = ptr_target - ptr_pos;
                    up   = (err <= 12'd2048);
                    mag  = up ? err : 12'd0 - err;
                    zone = (ptr_deadband == '0) ? 12'd1 : ptr_deadband;
                    if (mag >= zone) begin
                        res.moving = 1'b1;
                        if (ptr_ticks >= ptr_step_delay) begin
                            ptr_ticks     = 16'd0;
                            ptr_pos       = up ? ptr_pos + 12'd1 : ptr_pos - 12'd1;
                            ptr_energized = 1'b1;
                        end
                    end
                end
            end
            OP_TARGET: begin
                ptr_target = tgt[POSITION_W-1:0];
            end
            OP_SLEEP: begin
                ptr_energized = 1'b0;
                ptr_asleep    = 1'b1;
            end
            default: begin
                ptr_asleep    = 1'b0;
                ptr_energized = 1'b1;
            end
        endcase
        res.coils    = ptr_energized ? HALF_STEP_COILS[{ptr_pos[2:0], 2'b00} +: 4] : 4'd0;
        res.position = ptr_pos;
        return res;
    endfunction

    // Offer one item and hold it until the beat is taken.
    task automatic deliver_item(input t_op op, input logic [15:0] tgt,
                                input logic typed, input t_drive known);
        t_drive pred;
        item_ch.valid           <= 1'b1;
        item_ch.op              <= op;
        item_ch.target_position <= tgt;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        pred = advance_pointer(op, tgt);
        drive_queue.push_back(typed ? known : pred);
    endtask

    // Stop offering items and wait until every result has come back.
    task automatic settle_pointer();
        item_ch.valid <= 1'b0;
        while (drive_queue.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        settle_pointer();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_DEADBAND)
            ptr_deadband = data[DEADBAND_W-1:0];
        else
            ptr_step_delay = data;
    endtask

    // Mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: check each beat and vary the ready signal.
    always @(posedge i_clk) begin
        t_drive      exp_drive;
        int unsigned roll;
        logic        take;

        if (i_rst_n === 1'b1 && drive_ch.valid === 1'b1 && drive_ch.ready === 1'b1) begin
            if (drive_queue.size() == 0) begin
                report_mismatch("result beat with no item outstanding");
            end else begin
                exp_drive = drive_queue.pop_front();
                if (drive_ch.coils !== exp_drive.coils)
                    report_mismatch($sformatf("coils %h, expected %h",
                                              drive_ch.coils, exp_drive.coils));
                if (drive_ch.moving !== exp_drive.moving)
                    report_mismatch($sformatf("moving %b, expected %b",
                                              drive_ch.moving, exp_drive.moving));
                if (drive_ch.position !== exp_drive.position)
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              drive_ch.position, exp_drive.position));
            end
        end

        // A long hold-off asked for by the item side takes precedence.
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            stall_left   = LONG_STALL;
        end

        if (stall_left > 0) begin
            stall_left--;
            take = 1'b0;
        end else if (flow_left > 0) begin
            flow_left--;
            take = 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            take = 1'b1;
            if (roll < 3) begin
                flow_left = $urandom_range(40, 150);
            end else if (roll < 5) begin
                stall_left = $urandom_range(10, 35);
                take       = 1'b0;
            end else if (roll < 20) begin
                stall_left = $urandom_range(0, 2);
                take       = 1'b0;
            end
        end
        drive_ch.ready <= take;
    end

    // Run-away guard.
    initial begin
        #(4_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus: directed script, then random phases at several settings.
    initial begin
        t_phase          ph;
        t_script_row     row;
        t_op             op;
        logic [15:0]     tgt;
        logic [11:0]     near;
        int unsigned     roll;
        int unsigned     span;
        int unsigned     hi;
        int unsigned     gap;
        int unsigned     burst;
        int              offset;

        i_rst_n                 = 1'b0;
        item_ch.valid           = 1'b0;
        item_ch.op              = OP_TICK;
        item_ch.target_position = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = CFG_DEADBAND;
        cfg_ch.data             = '0;
        burst                   = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed script.
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED_SCRIPT[i];
            if (row.kind == ROW_CFG) begin
                write_register(row.index, row.value);
            end else begin
                deliver_item(row.op, row.value, row.typed, row.result);
                gap = pick_gap();
                if (gap > 0) begin
                    item_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++) begin
            ph = PHASE_PLAN[p];
            write_register(CFG_DEADBAND, {4'd0, ph.deadband});
            write_register(CFG_STEP_DELAY, ph.delay);
            for (int n = 0; n < int'(ph.items); n++) begin
                // Once per phase the item side waits for the pipe to empty.
                if (n == int'(ph.items) / 3)
                    settle_pointer();
                // Once per phase the result side holds off while items keep coming.
                if (n == int'(ph.items) / 2) begin
                    hold_requests++;
                    burst = 24;
                end

                tgt  = $urandom_range(0, 65535);
                roll = $urandom_range(0, 99);
                if (roll < 62) begin
                    op = OP_TICK;
                end else if (roll < 82) begin
                    // Targets mostly land near the pointer, around the dead zone edge.
                    op   = OP_TARGET;
                    hi   = $urandom_range(0, 15);
                    roll = $urandom_range(0, 99);
                    span = (ptr_deadband > 12'd2045) ? 2048 : ptr_deadband + 3;
                    if (roll < 70) begin
                        offset = int'($urandom_range(0, 2 * span)) - int'(span);
                        near   = ptr_pos + offset[11:0];
                        tgt    = {hi[3:0], near};
                    end else if (roll < 85) begin
                        near = ptr_pos + 12'd2048;
                        tgt  = {hi[3:0], near};
                    end
                end else if (roll < 92) begin
                    op = OP_WAKE;
                end else begin
                    op = OP_SLEEP;
                end

                deliver_item(op, tgt, 1'b0, '0);

                gap = 0;
                if (burst > 0)
                    burst--;
                else if (!ph.gapless)
                    gap = pick_gap();
                if (gap > 0) begin
                    item_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        // Drain and give the block time to show any stray beat.
        item_ch.valid <= 1'b0;
        while (drive_queue.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sppc_pkg.sv
hdl/sppc_in_if.sv
hdl/sppc_out_if.sv
hdl/sppc_cfg_if.sv
hdl/sppc_front.sv
hdl/sppc_core.sv
hdl/stepper_pointer_position_controller_top.sv
tb/sv/stepper_pointer_position_controller_top_test.sv
